### sv/ptsched_pkg.sv
package ptsched_pkg;

  // Command codes
  localparam logic [2:0] CMD_CREATE    = 3'd0;
  localparam logic [2:0] CMD_BLOCK     = 3'd1;
  localparam logic [2:0] CMD_BLOCK_CUR = 3'd2;
  localparam logic [2:0] CMD_UNBLOCK   = 3'd3;
  localparam logic [2:0] CMD_SLEEP_CUR = 3'd4;
  localparam logic [2:0] CMD_SWITCH    = 3'd5;

  // Thread states; codes below ST_WAITING are ready
  localparam logic [2:0] ST_QUEUED   = 3'd0;
  localparam logic [2:0] ST_PAUSED   = 3'd1;
  localparam logic [2:0] ST_ACTIVE   = 3'd2;
  localparam logic [2:0] ST_WAITING  = 3'd3;
  localparam logic [2:0] ST_SLEEPING = 3'd4;
  localparam logic [2:0] ST_BLOCKED  = 3'd5;

  // Result status
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_FULL      = 2'd1;
  localparam logic [1:0] STS_BAD_INDEX = 2'd2;
  localparam logic [1:0] STS_EMPTY     = 2'd3;

  // Controller -> datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic exec;      // decode and run single-write commands
    logic scan;      // table walk for switch
    logic commit;    // mark pick active
    logic out_load;  // load result register
  } ctl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic scan_req;   // switch on non-empty table
    logic scan_done;  // all entries processed
  } dp_stat_t;

endpackage

### sv/priority_thread_scheduler.sv
// Fixed-priority thread scheduler.
// Input stream: one beat per command (create, block, block_current, unblock,
// sleep_current, switch). Output stream: exactly one result beat per command
// with the running thread, the table fill count and a status code.
// A single-write command passes through exec and then the output state;
// switch walks the table once (read, wake/demote, compare per entry, one
// entry per cycle through the registered table read), then commits its pick
// before the output state. One command is in flight at a time, in_tready
// being high only while idle.
// The result register decouples the sides: a new command is accepted while
// the previous result still waits, and a finished result stalls in the
// controller until out_tready frees the register.
// Reset (rst_n low, synchronous) empties the table and points the running
// thread at 0; table contents need no clearing since every entry is written
// by create before any read.
module priority_thread_scheduler #(
  parameter int MAX_THREADS   = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] command, [6:3] thread_index, [14:7] priority_req,
  // [46:15] delay_ms, [78:47] now_ms, [79] zero
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] current_thread, [8:4] thread_count, [10:9] status, [15:11] zero
  output logic [15:0] out_tdata
);
  import ptsched_pkg::*;

  ctl_cmd_t   ctl;
  dp_stat_t   stat;
  logic [3:0] current_thread;
  logic [4:0] thread_count;
  logic [1:0] status;

  ptsched_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl),
    .stat       (stat)
  );

  ptsched_dp #(
    .MAX_THREADS   (MAX_THREADS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .stat           (stat),
    .command        (in_tdata[2:0]),
    .thread_index   (in_tdata[6:3]),
    .priority_req   (in_tdata[14:7]),
    .delay_ms       (in_tdata[46:15]),
    .now_ms         (in_tdata[78:47]),
    .current_thread (current_thread),
    .thread_count   (thread_count),
    .status         (status)
  );

  assign out_tdata = {5'b0, status, thread_count, current_thread};

endmodule

### sv/ptsched_dp.sv
module ptsched_dp #(
  parameter int MAX_THREADS   = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptsched_pkg::ctl_cmd_t ctl,
  output ptsched_pkg::dp_stat_t stat,
  input  logic [2:0]           command,
  input  logic [3:0]           thread_index,
  input  logic [7:0]           priority_req,
  input  logic [31:0]          delay_ms,
  input  logic [31:0]          now_ms,
  output logic [3:0]           current_thread,
  output logic [4:0]           thread_count,
  output logic [1:0]           status
);
  import ptsched_pkg::*;

  localparam int IW = $clog2(MAX_THREADS);
  localparam int CW = $clog2(MAX_THREADS + 1);
  localparam int PW = PRIORITY_BITS;

  // Thread table
  logic [2:0]    state_mem [MAX_THREADS];
  logic [PW-1:0] prio_mem  [MAX_THREADS];
  logic [31:0]   start_mem [MAX_THREADS];
  logic [31:0]   len_mem   [MAX_THREADS];

  // Captured command
  logic [2:0]    cmd_r;
  logic [3:0]    idx_r;
  logic [PW-1:0] prio_r;
  logic [31:0]   delay_r;
  logic [31:0]   now_r;

  logic [IW-1:0] running_r, running_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]    status_r, status_nxt;

  // Scan pipeline
  logic [CW-1:0] scan_addr_r;
  logic          issue_r;
  logic [IW-1:0] proc_idx_r;
  logic [IW-1:0] pick_r;
  logic [PW-1:0] pick_prio_r;
  logic [2:0]    pick_state_r;

  // Registered read data
  logic [2:0]    rd_state_r;
  logic [PW-1:0] rd_prio_r;
  logic [31:0]   rd_start_r;
  logic [31:0]   rd_len_r;

  logic [3:0]    cur_out_r;
  logic [4:0]    cnt_out_r;
  logic [1:0]    sts_out_r;

  // Write port
  logic          we_state, we_prio, we_sleep;
  logic [IW-1:0] wr_addr;
  logic [2:0]    wr_state;
  logic [31:0]   wr_start, wr_len;
  logic [IW-1:0] rd_addr;

  logic [PW+7:0] prio_ext;
  logic [CW+3:0] idx_ext, cnt_cmp;
  logic [IW+3:0] run_ext;
  logic [CW+4:0] cnt_ext;
  logic          idx_ok, tbl_full, tbl_empty;
  logic [31:0]   elapsed;
  logic [2:0]    eff_state;
  logic          take;

  assign prio_ext  = {{PW{1'b0}}, priority_req};
  assign idx_ext   = {{CW{1'b0}}, idx_r};
  assign cnt_cmp   = {4'b0, count_r};
  assign idx_ok    = idx_ext < cnt_cmp;
  assign tbl_full  = count_r == CW'(MAX_THREADS);
  assign tbl_empty = count_r == '0;
  assign rd_addr   = scan_addr_r[IW-1:0];

  // Wakeup / demote of the entry under scan
  assign elapsed = now_r - rd_start_r;
  always_comb begin
    eff_state = rd_state_r;
    if (rd_state_r == ST_SLEEPING && elapsed >= rd_len_r) begin
      eff_state = ST_PAUSED;
    end else if (proc_idx_r == running_r && rd_state_r == ST_ACTIVE) begin
      eff_state = ST_PAUSED;
    end
  end

  // Selection: lower priority wins; tie goes to paused over queued pick
  assign take = (eff_state < ST_WAITING) &&
                ((rd_prio_r < pick_prio_r) ||
                 (rd_prio_r == pick_prio_r && eff_state == ST_PAUSED &&
                  pick_state_r == ST_QUEUED));

  always_comb begin
    we_state    = 1'b0;
    we_prio     = 1'b0;
    we_sleep    = 1'b0;
    wr_addr     = running_r;
    wr_state    = ST_QUEUED;
    wr_start    = '0;
    wr_len      = '0;
    running_nxt = running_r;
    count_nxt   = count_r;
    status_nxt  = status_r;
    if (ctl.exec) begin
      status_nxt = STS_OK;
      case (cmd_r)
        CMD_CREATE: begin
          if (tbl_full) begin
            status_nxt = STS_FULL;
          end else begin
            we_state  = 1'b1;
            we_prio   = 1'b1;
            we_sleep  = 1'b1;
            wr_addr   = count_r[IW-1:0];
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_BLOCK, CMD_UNBLOCK: begin
          if (!idx_ok) begin
            status_nxt = STS_BAD_INDEX;
          end else begin
            we_state = 1'b1;
            wr_addr  = idx_ext[IW-1:0];
            wr_state = (cmd_r == CMD_BLOCK) ? ST_BLOCKED : ST_PAUSED;
          end
        end
        CMD_BLOCK_CUR: begin
          if (tbl_empty) begin
            status_nxt = STS_EMPTY;
          end else begin
            we_state = 1'b1;
            wr_state = ST_BLOCKED;
          end
        end
        CMD_SLEEP_CUR: begin
          if (tbl_empty) begin
            status_nxt = STS_EMPTY;
          end else begin
            we_state = 1'b1;
            we_sleep = 1'b1;
            wr_state = ST_SLEEPING;
            wr_start = now_r;
            wr_len   = delay_r;
          end
        end
        CMD_SWITCH: begin
          if (tbl_empty) begin
            status_nxt = STS_EMPTY;
          end
        end
        default: begin
        end
      endcase
    end else if (ctl.scan && issue_r) begin
      we_state = 1'b1;
      wr_addr  = proc_idx_r;
      wr_state = eff_state;
    end else if (ctl.commit) begin
      we_state    = 1'b1;
      wr_addr     = pick_r;
      wr_state    = ST_ACTIVE;
      running_nxt = pick_r;
    end
  end

  // Table memories
  always_ff @(posedge clk) begin
    if (we_state) begin
      state_mem[wr_addr] <= wr_state;
    end
    if (we_prio) begin
      prio_mem[wr_addr] <= prio_r;
    end
    if (we_sleep) begin
      start_mem[wr_addr] <= wr_start;
      len_mem[wr_addr]   <= wr_len;
    end
    rd_state_r <= state_mem[rd_addr];
    rd_prio_r  <= prio_mem[rd_addr];
    rd_start_r <= start_mem[rd_addr];
    rd_len_r   <= len_mem[rd_addr];
  end

  // Payload capture, pick tracking, result register
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= command;
      idx_r   <= thread_index;
      prio_r  <= prio_ext[PW-1:0];
      delay_r <= delay_ms;
      now_r   <= now_ms;
    end
    if (ctl.scan && issue_r) begin
      if (proc_idx_r == '0 || take) begin
        pick_r       <= proc_idx_r;
        pick_prio_r  <= rd_prio_r;
        pick_state_r <= eff_state;
      end
    end
    if (ctl.scan) begin
      proc_idx_r <= rd_addr;
    end
    if (ctl.out_load) begin
      cur_out_r <= run_ext[3:0];
      cnt_out_r <= cnt_ext[4:0];
      sts_out_r <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= '0;
      count_r     <= '0;
      status_r    <= STS_OK;
      scan_addr_r <= '0;
      issue_r     <= 1'b0;
    end else begin
      running_r <= running_nxt;
      count_r   <= count_nxt;
      status_r  <= status_nxt;
      if (ctl.exec) begin
        scan_addr_r <= '0;
        issue_r     <= 1'b0;
      end else if (ctl.scan) begin
        if (scan_addr_r != count_r) begin
          scan_addr_r <= scan_addr_r + 1'b1;
          issue_r     <= 1'b1;
        end else begin
          issue_r <= 1'b0;
        end
      end
    end
  end

  assign run_ext = {4'b0, running_r};
  assign cnt_ext = {5'b0, count_r};

  assign stat.scan_req  = (cmd_r == CMD_SWITCH) && !tbl_empty;
  assign stat.scan_done = (scan_addr_r == count_r) && !issue_r;

  assign current_thread = cur_out_r;
  assign thread_count   = cnt_out_r;
  assign status         = sts_out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_THREADS))
    else $error("thread count past table size");

  a_running_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0 |-> {{(CW+1){1'b0}}, running_r} < {{(IW+1){1'b0}}, count_r})
    else $error("running thread outside table");

endmodule

### sv/ptsched_ctrl.sv
module ptsched_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output ptsched_pkg::ctl_cmd_t ctl,
  input  ptsched_pkg::dp_stat_t stat
);
  import ptsched_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready = state_r == S_IDLE;

  always_comb begin
    state_nxt    = state_r;
    ctl          = '0;
    ctl.load     = in_tvalid && in_tready;
    case (state_r)
      S_IDLE: begin
        if (ctl.load) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        ctl.exec  = 1'b1;
        state_nxt = stat.scan_req ? S_SCAN : S_OUT;
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (stat.scan_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        ctl.commit = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = ctl.out_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten before taken");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == S_EXEC)
    else $error("accepted beat not executed");

endmodule

### dv/ptsched_checker.sv
`timescale 1ns / 1ps

// Scoreboard for the thread scheduler: keeps a shadow thread table, predicts
// one result beat per accepted command beat and compares in order.
module ptsched_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  output int          fail_count,
  output int          backlog,
  output int          results_seen
);
  import ptsched_pkg::*;

  localparam int NUM_SLOTS = 16;

  typedef struct packed {
    logic [3:0] current_thread;
    logic [4:0] thread_count;
    logic [1:0] status;
  } sched_result_t;

  // shadow thread table
  logic [7:0]  prio_tbl  [NUM_SLOTS];
  logic [2:0]  state_tbl [NUM_SLOTS];
  logic [31:0] nap_base  [NUM_SLOTS];
  logic [31:0] nap_len   [NUM_SLOTS];
  logic [3:0]  running;
  logic [4:0]  filled;

  sched_result_t due_results[$];
  int errs;
  int seen;

  // Update the shadow table for one command and return the result it gives.
  function automatic sched_result_t apply_command(logic [79:0] beat);
    logic [2:0]    op;
    logic [3:0]    idx;
    logic [7:0]    prio;
    logic [31:0]   delay;
    logic [31:0]   now;
    logic [31:0]   elapsed;
    logic [1:0]    sts;
    int            pick;
    sched_result_t r;
    op    = beat[2:0];
    idx   = beat[6:3];
    prio  = beat[14:7];
    delay = beat[46:15];
    now   = beat[78:47];
    sts   = STS_OK;
    case (op)
      CMD_CREATE: begin
        if (filled >= NUM_SLOTS) begin
          sts = STS_FULL;
        end else begin
          prio_tbl[filled]  = prio;
          state_tbl[filled] = ST_QUEUED;
          nap_base[filled]  = '0;
          nap_len[filled]   = '0;
          filled++;
        end
      end
      CMD_BLOCK, CMD_UNBLOCK: begin
        if (idx >= filled) sts = STS_BAD_INDEX;
        else state_tbl[idx] = (op == CMD_BLOCK) ? ST_BLOCKED : ST_PAUSED;
      end
      CMD_BLOCK_CUR: begin
        if (filled == 0) sts = STS_EMPTY;
        else state_tbl[running] = ST_BLOCKED;
      end
      CMD_SLEEP_CUR: begin
        if (filled == 0) begin
          sts = STS_EMPTY;
        end else begin
          state_tbl[running] = ST_SLEEPING;
          nap_len[running]   = delay;
          nap_base[running]  = now;
        end
      end
      CMD_SWITCH: begin
        if (filled == 0) begin
          sts = STS_EMPTY;
        end else begin
          // wake sleepers, elapsed time wraps at 32 bits
          for (int i = 0; i < filled; i++) begin
            elapsed = now - nap_base[i];
            if (state_tbl[i] == ST_SLEEPING && elapsed >= nap_len[i])
              state_tbl[i] = ST_PAUSED;
          end
          if (state_tbl[running] == ST_ACTIVE) state_tbl[running] = ST_PAUSED;
          // slot 0 is the starting pick, ready or not
          pick = 0;
          for (int i = 1; i < filled; i++) begin
            if (state_tbl[i] < ST_WAITING) begin
              if (prio_tbl[i] < prio_tbl[pick])
                pick = i;
              else if (prio_tbl[i] == prio_tbl[pick] && state_tbl[i] == ST_PAUSED &&
                       state_tbl[pick] == ST_QUEUED)
                pick = i;
            end
          end
          running         = pick[3:0];
          state_tbl[pick] = ST_ACTIVE;
        end
      end
      default: ;
    endcase
    r.current_thread = running;
    r.thread_count   = filled;
    r.status         = sts;
    return r;
  endfunction

  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (!rst_n) begin
      running = '0;
      filled  = '0;
      due_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.current_thread = out_tdata[3:0];
        got.thread_count   = out_tdata[8:4];
        got.status         = out_tdata[10:9];
        seen++;
        if (due_results.size() == 0) begin
          $error("result beat with nothing expected: %h", out_tdata);
          errs++;
        end else begin
          want = due_results.pop_front();
          if (got.current_thread !== want.current_thread) begin
            $error("current_thread: expected %0d, actual %0d",
                   want.current_thread, got.current_thread);
            errs++;
          end
          if (got.thread_count !== want.thread_count) begin
            $error("thread_count: expected %0d, actual %0d",
                   want.thread_count, got.thread_count);
            errs++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready) due_results.push_back(apply_command(in_tdata));
    end
    // published after the edge so the top never races the update
    fail_count   <= errs;
    backlog      <= due_results.size();
    results_seen <= seen;
  end

endmodule

### dv/tb_priority_thread_scheduler.sv
`timescale 1ns / 1ps

// Top of the scheduler bench: clock, reset, command stimulus, result-side
// backpressure and the verdict. All prediction lives in ptsched_checker.
module tb_priority_thread_scheduler;
  import ptsched_pkg::*;

  localparam int ITEMS     = 1750;
  localparam int CALM_TAIL = 250;     // final stretch runs with no idling
  localparam int LIMIT     = 600000;  // several times the slowest legal run
  localparam int NUM_SLOTS = 16;

  // codes the block decodes as no-ops
  localparam logic [2:0] CMD_RSVD_A = 3'd6;
  localparam logic [2:0] CMD_RSVD_B = 3'd7;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  // [2:0] command, [6:3] thread_index, [14:7] priority_req,
  // [46:15] delay_ms, [78:47] now_ms, [79] zero
  logic [79:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [3:0] current_thread, [8:4] thread_count, [10:9] status, [15:11] zero
  logic [15:0] out_tdata;

  int fail_count;
  int backlog;
  int results_seen;

  // stimulus-side bookkeeping
  int          slots_used = 0;   // creates that landed, capped at table size
  int          issued[8];        // accepted beats per command code
  logic [31:0] clock_ms   = 32'hFFFF_F000;  // starts near wrap on purpose
  bit          calm       = 1'b0;
  bit          stalls_on  = 1'b0;
  int          cycles     = 0;

  priority_thread_scheduler uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  ptsched_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .backlog     (backlog),
    .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: covers a hung handshake or a result that never shows up.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result-side backpressure: ready drops in bursts of random length while
  // stalls are enabled, held high otherwise and through the calm tail.
  always @(negedge clk) begin
    int stall_left;
    if (calm) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (stalls_on && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 16);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // One command beat: present at the falling edge, hold until accepted.
  // Back-to-back calls keep tvalid high across beats.
  task automatic send_command(input logic [2:0] op, input logic [3:0] idx,
                              input logic [7:0] prio, input logic [31:0] delay,
                              input logic [31:0] now);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, now, delay, prio, idx, op};
    do @(posedge clk); while (!in_tready);
    issued[op]++;
    if (op == CMD_CREATE && slots_used < NUM_SLOTS) slots_used++;
  endtask

  // Drop tvalid and keep the input idle for a span set by n.
  task automatic rest_input(input int n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (n - 1) @(posedge clk);
  endtask

  initial begin
    int          n;
    int          roll;
    bit          bursty;
    logic [2:0]  op;
    logic [3:0]  idx;
    logic [7:0]  prio;
    logic [31:0] delay;
    logic [31:0] now;

    bursty = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed ----
    // empty table: every command that needs an entry is refused
    send_command(CMD_SWITCH,    4'd0,  8'd0, 32'd0, 32'd0);
    send_command(CMD_BLOCK_CUR, 4'd0,  8'd0, 32'd0, 32'd0);
    send_command(CMD_SLEEP_CUR, 4'd0,  8'd0, 32'd5, 32'd0);
    send_command(CMD_BLOCK,     4'd0,  8'd0, 32'd0, 32'd0);
    send_command(CMD_UNBLOCK,   4'd15, 8'd0, 32'd0, 32'd0);
    send_command(CMD_RSVD_A,    4'd15, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // priority extremes
    send_command(CMD_CREATE,    4'd0,  8'hFF, 32'd0, 32'd0);
    send_command(CMD_CREATE,    4'd0,  8'h00, 32'd0, 32'd0);
    // index just past the fill count
    send_command(CMD_BLOCK,     4'd2,  8'd0, 32'd0, 32'd0);
    send_command(CMD_SWITCH,    4'd0,  8'd0, 32'd0, 32'd1);
    // block the running thread, no switch until asked
    send_command(CMD_BLOCK_CUR, 4'd0,  8'd0, 32'd0, 32'd2);
    send_command(CMD_SWITCH,    4'd0,  8'd0, 32'd0, 32'd3);
    // unblock the active thread too: it just becomes paused
    send_command(CMD_UNBLOCK,   4'd1,  8'd0, 32'd0, 32'd4);
    send_command(CMD_UNBLOCK,   4'd0,  8'd0, 32'd0, 32'd4);
    // equal priority: queued newcomer must not beat a paused pick
    send_command(CMD_CREATE,    4'd0,  8'h00, 32'd0, 32'd5);
    send_command(CMD_SWITCH,    4'd0,  8'd0, 32'd0, 32'd6);
    // longest sleep across the 32-bit wrap: not due at +0x20, due at -1
    send_command(CMD_SLEEP_CUR, 4'd0,  8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    send_command(CMD_SWITCH,    4'd0,  8'd0, 32'd0, 32'h0000_0010);
    send_command(CMD_BLOCK,     4'd0,  8'd0, 32'd0, 32'd0);
    send_command(CMD_SWITCH,    4'd0,  8'd0, 32'd0, 32'hFFFF_FFEF);
    // nothing ready: thread 0 still gets picked
    send_command(CMD_BLOCK_CUR, 4'd0,  8'd0, 32'd0, 32'd0);
    send_command(CMD_BLOCK,     4'd2,  8'd0, 32'd0, 32'd0);
    send_command(CMD_SWITCH,    4'd0,  8'd0, 32'd0, 32'hFFFF_FFF0);
    send_command(CMD_RSVD_B,    4'd0,  8'd0, 32'd0, 32'd0);

    // ---- random ----
    // Mostly a sane OS-like mix on a slowly growing table with a ticking
    // clock; creates keep trickling in after the table is full.
    for (n = 0; n < ITEMS; n++) begin
      if (n % 120 == 0) bursty = ($urandom_range(0, 2) != 0);
      calm      = (n >= ITEMS - CALM_TAIL);
      stalls_on = bursty && !calm;

      // hold off once until every result has drained
      if (n == ITEMS / 2) begin
        rest_input(1);
        while (backlog != 0) @(posedge clk);
      end
      if (stalls_on && $urandom_range(0, 5) == 0) rest_input($urandom_range(1, 17));

      roll = $urandom_range(0, 99);
      if (roll < ((slots_used < NUM_SLOTS) ? 6 : 3)) op = CMD_CREATE;
      else if (roll < 16) op = CMD_BLOCK;
      else if (roll < 25) op = CMD_BLOCK_CUR;
      else if (roll < 41) op = CMD_UNBLOCK;
      else if (roll < 53) op = CMD_SLEEP_CUR;
      else if (roll < 97) op = CMD_SWITCH;
      else op = $urandom_range(0, 1) ? CMD_RSVD_A : CMD_RSVD_B;

      if (slots_used > 0 && $urandom_range(0, 9) != 0)
        idx = 4'($urandom_range(0, slots_used - 1));
      else
        idx = 4'($urandom_range(0, 15));

      // small priorities make ties common
      prio  = ($urandom_range(0, 4) < 3) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      delay = ($urandom_range(0, 9) != 0) ? 32'($urandom_range(0, 60)) : 32'($urandom);

      clock_ms += $urandom_range(0, 6);
      if ($urandom_range(0, 49) == 0) clock_ms += $urandom;
      now = (op == CMD_SWITCH || op == CMD_SLEEP_CUR) ? clock_ms : 32'($urandom);

      send_command(op, idx, prio, delay, now);
    end

    // ---- drain ----
    rest_input(1);
    while (backlog != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d results checked: %0d create, %0d block, %0d block_current, %0d unblock,",
             results_seen, issued[CMD_CREATE], issued[CMD_BLOCK], issued[CMD_BLOCK_CUR],
             issued[CMD_UNBLOCK]);
    $display("  %0d sleep_current, %0d switch, %0d no-op codes; table reached %0d threads",
             issued[CMD_SLEEP_CUR], issued[CMD_SWITCH],
             issued[CMD_RSVD_A] + issued[CMD_RSVD_B], slots_used);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
